// ===== rtl/core/dtam_pkg.sv =====
// dtam_pkg: shared types, constants and month length table for the
// datetime minute adder; no dependencies
package dtam_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int ADD_W    = 15;

    localparam int PIPE_DEPTH = 5;

    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR  = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN  = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP  = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV  = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;

    typedef struct packed {
        logic [YEAR_W-1:0]   start_year;
        logic [MONTH_W-1:0]  start_month;
        logic [DAY_W-1:0]    start_day;
        logic [HOUR_W-1:0]   start_hour;
        logic [MINUTE_W-1:0] start_minute;
        logic [ADD_W-1:0]    add_minutes;
    } in_word_t;

    typedef struct packed {
        logic [YEAR_W-1:0]   end_year;
        logic [MONTH_W-1:0]  end_month;
        logic [DAY_W-1:0]    end_day;
        logic [HOUR_W-1:0]   end_hour;
        logic [MINUTE_W-1:0] end_minute;
        logic                year_overflow;
    } out_word_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    typedef struct packed {
        logic                valid;
        logic [MINUTE_W-1:0] minute;
        logic [HOUR_W-1:0]   hour;
        logic [DAY_W-1:0]    days;
    } time_res_t;

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
        logic [DAY_W-1:0] d;
        unique case (month) inside
            MONTH_FEB:                               d = leap ? 5'd29 : 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: d = 5'd30;
            default:                                 d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/core/dtam_leap.sv =====
// dtam_leap: two-stage leap year test of a 14-bit year
// depends on dtam_pkg
module dtam_leap (
    input  logic                           clk,
    input  logic [dtam_pkg::YEAR_W-1:0]    year,
    output logic                           leap
);

    logic [26:0]                     prod;
    logic [9:0]                      q25_reg;
    logic [dtam_pkg::YEAR_W-1:0]     year_reg;
    logic [14:0]                     back;
    logic                            div25;
    logic                            leap_reg;

    // floor(year / 25) by reciprocal 5243 / 2^17
    assign prod = 27'(year) * 27'd5243;

    always_ff @(posedge clk)
    begin
        q25_reg  <= prod[26:17];
        year_reg <= year;
    end

    assign back  = 15'(q25_reg) * 15'd25;
    assign div25 = (back == 15'(year_reg));

    always_ff @(posedge clk)
    begin
        leap_reg <= (year_reg[1:0] == 2'd0) && (!div25 || (year_reg[3:0] == 4'd0));
    end

    assign leap = leap_reg;

endmodule

// ===== rtl/core/dtam_time_split.sv =====
// dtam_time_split: four-stage split of hour, minute and added minutes
// into minute, hour and whole days; depends on dtam_pkg
module dtam_time_split (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic [dtam_pkg::HOUR_W-1:0]     hour,
    input  logic [dtam_pkg::MINUTE_W-1:0]   minute,
    input  logic [dtam_pkg::ADD_W-1:0]      add_minutes,
    output dtam_pkg::time_res_t             res
);

    logic [3:0]  valid_reg;
    logic [15:0] total_next;
    logic [15:0] total_reg;
    logic [15:0] total2_reg;
    logic [31:0] prod60_reg;
    logic [9:0]  q60;
    logic [15:0] back60;
    logic [9:0]  q60_reg;
    logic [5:0]  minute3_reg;
    logic [19:0] prod24_reg;
    logic [4:0]  q24;
    logic [9:0]  back24;
    logic [5:0]  minute4_reg;
    logic [4:0]  hour4_reg;
    logic [4:0]  days4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    assign total_next = 16'(hour) * 16'd60 + 16'(minute) + 16'(add_minutes);

    // floor(total / 60) by 34953 / 2^21, floor(q / 24) by 1366 / 2^15
    assign q60    = prod60_reg[30:21];
    assign back60 = 16'(q60) * 16'd60;
    assign q24    = prod24_reg[19:15];
    assign back24 = 10'(q24) * 10'd24;

    always_ff @(posedge clk)
    begin
        total_reg   <= total_next;
        total2_reg  <= total_reg;
        prod60_reg  <= 32'(total_reg) * 32'd34953;
        q60_reg     <= q60;
        minute3_reg <= 6'(total2_reg - back60);
        prod24_reg  <= 20'(q60) * 20'd1366;
        minute4_reg <= minute3_reg;
        hour4_reg   <= 5'(q60_reg - back24);
        days4_reg   <= q24;
    end

    assign res.valid  = valid_reg[3];
    assign res.minute = minute4_reg;
    assign res.hour   = hour4_reg;
    assign res.days   = days4_reg;

endmodule

// ===== rtl/core/dtam_date_carry.sv =====
// dtam_date_carry: final stage, day carry into month and year, year
// saturation and result register; depends on dtam_pkg
module dtam_date_carry (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dtam_pkg::date_t       date,
    input  logic                  leap,
    input  dtam_pkg::time_res_t   tres,
    output logic                  result_valid,
    output dtam_pkg::out_word_t   result
);

    logic [5:0]                       day_sum;
    logic [dtam_pkg::DAY_W-1:0]       dim;
    logic                             carry;
    logic [dtam_pkg::MONTH_W-1:0]     month_next;
    logic [dtam_pkg::YEAR_W:0]        year_next;
    logic [dtam_pkg::DAY_W-1:0]       day_next;
    logic                             over;
    logic                             valid_reg;
    dtam_pkg::out_word_t              result_reg;
    dtam_pkg::out_word_t              result_next;

    assign day_sum = 6'(date.day) + 6'(tres.days);
    assign dim     = dtam_pkg::month_days(date.month, leap);
    assign carry   = (day_sum > 6'(dim));

    always_comb
    begin
        month_next = date.month;
        year_next  = (dtam_pkg::YEAR_W+1)'(date.year);
        day_next   = day_sum[dtam_pkg::DAY_W-1:0];
        if (carry)
        begin
            day_next = 5'(day_sum - 6'(dim));
            if (date.month == dtam_pkg::MONTH_DEC)
            begin
                month_next = dtam_pkg::MONTH_JAN;
                year_next  = year_next + (dtam_pkg::YEAR_W+1)'(1);
            end
            else
            begin
                month_next = date.month + dtam_pkg::MONTH_W'(1);
            end
        end
        over = (year_next > (dtam_pkg::YEAR_W+1)'(dtam_pkg::YEAR_MAX));
        result_next.end_year      = over ? dtam_pkg::YEAR_MAX
                                         : year_next[dtam_pkg::YEAR_W-1:0];
        result_next.end_month     = month_next;
        result_next.end_day       = day_next;
        result_next.end_hour      = tres.hour;
        result_next.end_minute    = tres.minute;
        result_next.year_overflow = over;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= tres.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

// ===== rtl/core/datetime_add_minutes_core.sv =====
// datetime_add_minutes_core: top level of the pipelined datetime minute adder
// depends on dtam_pkg, dtam_leap, dtam_time_split, dtam_date_carry
//
//   port          dir  width  role
//   start         in   1      request word offered
//   busy          out  1      always low, a word is taken every cycle
//   request       in   49     in_word_t, start date, time and minutes to add
//   result_valid  out  1      one-cycle strobe with each result word
//   result        out  35     out_word_t, normalized date and time
//
// one word accepted per cycle, result strobed at the end of the five register
// stages of the pipeline (three constant-reciprocal divisions, one month
// carry). reset clears only the valid bits; payload registers are not reset.
// nothing stalls: the receiver takes every result.
module datetime_add_minutes_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  dtam_pkg::in_word_t    request,
    output logic                  result_valid,
    output dtam_pkg::out_word_t   result
);

    logic                  accept;
    dtam_pkg::date_t       date_in;
    dtam_pkg::date_t       date_pipe_reg [4];
    logic                  leap_early;
    logic [1:0]            leap_pipe_reg;
    dtam_pkg::time_res_t   tres;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // month clamped to 1..12, day zero read as one
    always_comb
    begin
        date_in.year  = request.start_year;
        date_in.month = request.start_month;
        date_in.day   = request.start_day;
        if (request.start_month == 4'd0)
        begin
            date_in.month = dtam_pkg::MONTH_JAN;
        end
        else if (request.start_month > dtam_pkg::MONTH_DEC)
        begin
            date_in.month = dtam_pkg::MONTH_DEC;
        end
        if (request.start_day == 5'd0)
        begin
            date_in.day = 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        date_pipe_reg[0] <= date_in;
        date_pipe_reg[1] <= date_pipe_reg[0];
        date_pipe_reg[2] <= date_pipe_reg[1];
        date_pipe_reg[3] <= date_pipe_reg[2];
        leap_pipe_reg    <= {leap_pipe_reg[0], leap_early};
    end

    dtam_leap u_leap (
        .clk  (clk),
        .year (request.start_year),
        .leap (leap_early)
    );

    dtam_time_split u_time (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (accept),
        .hour        (request.start_hour),
        .minute      (request.start_minute),
        .add_minutes (request.add_minutes),
        .res         (tres)
    );

    dtam_date_carry u_carry (
        .clk          (clk),
        .rst_n        (rst_n),
        .date         (date_pipe_reg[3]),
        .leap         (leap_pipe_reg[1]),
        .tres         (tres),
        .result_valid (result_valid),
        .result       (result)
    );

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(accept, dtam_pkg::PIPE_DEPTH))
        else $error("result strobe without a matching accepted word");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.end_hour < 5'd24) && (result.end_minute < 6'd60))
        else $error("hour or minute out of range");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.end_month >= dtam_pkg::MONTH_JAN)
                      && (result.end_month <= dtam_pkg::MONTH_DEC)
                      && (result.end_day != 5'd0))
        else $error("month or day out of range");

    a_saturate: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.year_overflow) |-> (result.end_year == dtam_pkg::YEAR_MAX))
        else $error("overflow without saturated year");
`endif

endmodule

// ===== test/tb_datetime_add_minutes_core.sv =====
// tb_datetime_add_minutes_core: self-checking bench for the datetime minute adder,
// a directed set of calendar corner cases then random words in three idle phases
// depends on dtam_pkg and datetime_add_minutes_core
module tb_datetime_add_minutes_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MIN_PER_HOUR  = 60;
    localparam int unsigned HOURS_PER_DAY = 24;
    localparam int unsigned RANDOM_WORDS  = 2000;
    localparam int unsigned STALL_LIMIT   = 5000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    dtam_pkg::in_word_t  request = '0;
    logic                result_valid;
    dtam_pkg::out_word_t result;

    dtam_pkg::in_word_t  pending_words[$];
    dtam_pkg::out_word_t expected_results[$];
    int unsigned idle_pct = 15;
    int unsigned mismatch_count = 0;
    int unsigned stall_cycles = 0;

    datetime_add_minutes_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result)
    );

    always #10 clk = ~clk;

    function automatic int unsigned month_length(input int unsigned yr, input int unsigned mo);
        logic leap;
        leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
        if (mo == 32'(dtam_pkg::MONTH_FEB))
            return leap ? 29 : 28;
        if (mo == 32'(dtam_pkg::MONTH_APR) || mo == 32'(dtam_pkg::MONTH_JUN)
            || mo == 32'(dtam_pkg::MONTH_SEP) || mo == 32'(dtam_pkg::MONTH_NOV))
            return 30;
        return 31;
    endfunction

    function automatic dtam_pkg::out_word_t add_minutes_to_date(input dtam_pkg::in_word_t w);
        int unsigned yr;
        int unsigned mo;
        int unsigned dy;
        int unsigned total;
        int unsigned dim;
        dtam_pkg::out_word_t r;
        yr = 32'(w.start_year);
        mo = 32'(w.start_month);
        dy = 32'(w.start_day);
        if (mo == 0)
            mo = 32'(dtam_pkg::MONTH_JAN);
        if (mo > 32'(dtam_pkg::MONTH_DEC))
            mo = 32'(dtam_pkg::MONTH_DEC);
        if (dy == 0)
            dy = 1;
        total = 32'(w.start_hour) * MIN_PER_HOUR + 32'(w.start_minute)
              + 32'(w.add_minutes);
        r.end_minute = dtam_pkg::MINUTE_W'(total % MIN_PER_HOUR);
        total = total / MIN_PER_HOUR;
        r.end_hour = dtam_pkg::HOUR_W'(total % HOURS_PER_DAY);
        dy = dy + total / HOURS_PER_DAY;
        dim = month_length(yr, mo);
        while (dy > dim)
        begin
            dy = dy - dim;
            mo = mo + 1;
            if (mo > 32'(dtam_pkg::MONTH_DEC))
            begin
                mo = 32'(dtam_pkg::MONTH_JAN);
                yr = yr + 1;
            end
            dim = month_length(yr, mo);
        end
        r.year_overflow = (yr > 32'(dtam_pkg::YEAR_MAX));
        r.end_year = (yr > 32'(dtam_pkg::YEAR_MAX)) ? dtam_pkg::YEAR_MAX
                                                    : yr[dtam_pkg::YEAR_W-1:0];
        r.end_month = mo[dtam_pkg::MONTH_W-1:0];
        r.end_day = dy[dtam_pkg::DAY_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatch_count++;
        $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    task automatic push_word(input int unsigned yr, input int unsigned mo,
                             input int unsigned dy, input int unsigned hr,
                             input int unsigned mi, input int unsigned add);
        dtam_pkg::in_word_t w;
        w.start_year = yr[dtam_pkg::YEAR_W-1:0];
        w.start_month = mo[dtam_pkg::MONTH_W-1:0];
        w.start_day = dy[dtam_pkg::DAY_W-1:0];
        w.start_hour = hr[dtam_pkg::HOUR_W-1:0];
        w.start_minute = mi[dtam_pkg::MINUTE_W-1:0];
        w.add_minutes = add[dtam_pkg::ADD_W-1:0];
        pending_words.push_back(w);
    endtask

    task automatic push_random_words(input int unsigned count);
        int unsigned yr;
        int unsigned mo;
        int unsigned dy;
        int unsigned add;
        int unsigned pick;
        repeat (count)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                // raw noise over every bit of every field
                push_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    yr = $urandom_range(9998, 9999);
                else if (pick == 1)
                    yr = 100 * $urandom_range(17, 99);
                else
                    yr = $urandom_range(1601, 9999);
                mo = $urandom_range(1, 12);
                if ($urandom_range(0, 1) == 0)
                    dy = $urandom_range(1, month_length(yr, mo));
                else
                    dy = month_length(yr, mo) - $urandom_range(0, 2);
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    add = $urandom_range(0, 1440);
                else if (pick < 7)
                    add = $urandom_range(0, 32767);
                else
                    add = $urandom_range(30000, 32767);
                push_word(yr, mo, dy, $urandom_range(0, 23), $urandom_range(0, 59), add);
            end
        end
    endtask

    // driver: holds the word until taken, then optionally idles
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        logic take_next;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
                expected_results.push_back(add_minutes_to_date(request));
            take_next = !start || !busy;
            if (take_next)
            begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    start <= 1'b1;
                    request <= pending_words.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: compares each result word with the oldest prediction
    always @(posedge clk)
    begin : check_results
        dtam_pkg::out_word_t want;
        if (rst_n && result_valid)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result word, end_year", result.end_year, 0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.end_year !== want.end_year)
                    report_mismatch("end_year", result.end_year, want.end_year);
                if (result.end_month !== want.end_month)
                    report_mismatch("end_month", result.end_month, want.end_month);
                if (result.end_day !== want.end_day)
                    report_mismatch("end_day", result.end_day, want.end_day);
                if (result.end_hour !== want.end_hour)
                    report_mismatch("end_hour", result.end_hour, want.end_hour);
                if (result.end_minute !== want.end_minute)
                    report_mismatch("end_minute", result.end_minute, want.end_minute);
                if (result.year_overflow !== want.year_overflow)
                    report_mismatch("year_overflow", result.year_overflow,
                                    want.year_overflow);
            end
        end
    end

    // watchdog on cycles with no word moving either way
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        push_word(2024, 1, 1, 0, 0, 0);
        push_word(1601, 1, 1, 0, 0, 32767);
        push_word(9999, 12, 31, 23, 59, 1);
        push_word(9999, 12, 31, 23, 59, 0);
        push_word(16383, 15, 31, 31, 63, 32767);
        push_word(0, 0, 0, 0, 0, 0);
        push_word(2024, 2, 28, 23, 30, 30);
        push_word(2023, 2, 28, 23, 30, 30);
        push_word(1900, 2, 28, 12, 0, 720);
        push_word(2000, 2, 28, 12, 0, 720);
        push_word(2024, 13, 15, 10, 0, 60);
        push_word(2024, 0, 10, 0, 0, 0);
        push_word(2024, 3, 0, 5, 5, 5);
        push_word(2023, 4, 31, 0, 0, 0);
        push_word(2023, 2, 31, 0, 0, 0);
        push_word(2024, 5, 10, 31, 63, 0);
        push_word(1500, 2, 28, 0, 0, 1440);
        push_word(12000, 6, 1, 0, 0, 0);
        push_word(2023, 12, 31, 23, 59, 1);
        push_word(2023, 1, 31, 0, 0, 32767);
        push_word(9999, 12, 10, 0, 0, 32767);
        push_word(2024, 6, 30, 0, 0, 1440);
        push_random_words(RANDOM_WORDS / 3);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || start) @(negedge clk);
        idle_pct = 80;
        push_random_words(RANDOM_WORDS / 3);
        while (pending_words.size() != 0 || start) @(negedge clk);
        idle_pct = 0;
        push_random_words(RANDOM_WORDS / 3);
        while (pending_words.size() != 0 || start) @(negedge clk);

        while (expected_results.size() != 0) @(negedge clk);
        repeat (dtam_pkg::PIPE_DEPTH + 4) @(negedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results never seen", 0, expected_results.size());
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== datetime_add_minutes_core.f =====
rtl/core/dtam_pkg.sv
rtl/core/dtam_leap.sv
rtl/core/dtam_time_split.sv
rtl/core/dtam_date_carry.sv
rtl/core/datetime_add_minutes_core.sv
test/tb_datetime_add_minutes_core.sv
